// ===== rtl/j1939_pgn_field_decoder_unit_macros.svh =====
// Assertion macros shared by the PGN decoder RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef J1939_PGN_FIELD_DECODER_UNIT_MACROS_SVH
`define J1939_PGN_FIELD_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGND_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pgnd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pgnd assertion failed");

`endif

// ===== rtl/pgnd_pkg.sv =====
// Shared types and constants of the PGN decoder: kind codes, known PGNs,
// queue entry layout and reciprocal constants. No dependencies.
`default_nettype none

package pgnd_pkg;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_UNKNOWN   = 3'd0,
		KIND_ENGINE    = 3'd1,
		KIND_SPEED     = 3'd2,
		KIND_REAR_HTCH = 3'd3,
		KIND_FRNT_HTCH = 3'd4,
		KIND_REAR_PTO  = 3'd5,
		KIND_FRNT_PTO  = 3'd6,
		KIND_CURVE     = 3'd7
	} kind_t;

	// Known parameter groups
	localparam logic [15:0] PGN_ENGINE_SPEED = 16'd61444;
	localparam logic [15:0] PGN_WHEEL_SPEED  = 16'd65096;
	localparam logic [15:0] PGN_REAR_HITCH   = 16'd65093;
	localparam logic [15:0] PGN_FRONT_HITCH  = 16'd65094;
	localparam logic [15:0] PGN_REAR_PTO     = 16'd65091;
	localparam logic [15:0] PGN_FRONT_PTO    = 16'd65092;
	localparam logic [15:0] PGN_CURVATURE    = 16'hAC00;
	localparam logic [7:0]  PDU2_THRESHOLD   = 8'hEF;

	// Curvature offset in quarter units
	localparam logic [16:0] CURVE_OFFSET_Q = 17'd32128;

	// x/1000 = (x * RECIP_1000) >> 26, exact for 16-bit x
	localparam logic [16:0] RECIP_1000 = 17'd67109;
	localparam int          SHIFT_1000 = 26;
	// x/255 = (x * RECIP_255) >> 23, exact for x below 66052
	localparam logic [16:0] RECIP_255  = 17'd32897;
	localparam int          SHIFT_255  = 23;

	// Queue depth between classifier and value unit
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [15:0] pgn;
		kind_t       kind;
		logic [15:0] operand;
	} pgnd_entry_t;

endpackage

`default_nettype wire

// ===== rtl/pgnd_if.sv =====
// Valid/ready channel interfaces of the PGN decoder: received frame in,
// decoded result out. No dependencies.
`default_nettype none

interface pgnd_in_if;
	logic        valid;
	logic        ready;
	logic [28:0] frame_id;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;

	modport source (output valid, frame_id, byte0, byte1, byte2, byte3, byte4,
		input ready);
	modport sink (input valid, frame_id, byte0, byte1, byte2, byte3, byte4,
		output ready);
endinterface

interface pgnd_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        pgn;
	logic [2:0]         kind;
	logic signed [16:0] value;

	modport source (output valid, pgn, kind, value, input ready);
	modport sink (input valid, pgn, kind, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/pgnd_front.sv =====
// Front end: accepts received frames, derives the PGN, classifies the kind
// and selects the raw operand. Uses pgnd_pkg and pgnd_in_if.
`default_nettype none

module pgnd_front
	import pgnd_pkg::*;
(
	pgnd_in_if.sink     in_ch,
	input  wire logic   q_full,
	output pgnd_entry_t push_entry,
	output logic        push
);

	logic [7:0]  pf;
	logic [15:0] pgn;
	logic [15:0] raw01;
	logic [15:0] raw34;

	// Beat is taken whenever the queue has room
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	// PGN derivation: PDU2 keeps the group extension, PDU1 drops destination
	assign pf    = in_ch.frame_id[23:16];
	assign pgn   = (pf > PDU2_THRESHOLD) ? in_ch.frame_id[23:8] : {pf, 8'h00};
	assign raw01 = {in_ch.byte1, in_ch.byte0};
	assign raw34 = {in_ch.byte4, in_ch.byte3};

	// Classification and operand select
	always_comb begin
		push_entry.pgn     = pgn;
		push_entry.kind    = KIND_UNKNOWN;
		push_entry.operand = '0;
		case (pgn)
			PGN_ENGINE_SPEED: begin
				push_entry.kind    = KIND_ENGINE;
				push_entry.operand = raw34;
			end
			PGN_WHEEL_SPEED: begin
				push_entry.kind    = KIND_SPEED;
				push_entry.operand = raw01;
			end
			PGN_REAR_HITCH: begin
				push_entry.kind    = KIND_REAR_HTCH;
				push_entry.operand = {8'h00, in_ch.byte0};
			end
			PGN_FRONT_HITCH: begin
				push_entry.kind    = KIND_FRNT_HTCH;
				push_entry.operand = {8'h00, in_ch.byte0};
			end
			PGN_REAR_PTO: begin
				push_entry.kind    = KIND_REAR_PTO;
				push_entry.operand = raw01;
			end
			PGN_FRONT_PTO: begin
				push_entry.kind    = KIND_FRNT_PTO;
				push_entry.operand = raw01;
			end
			PGN_CURVATURE: begin
				push_entry.kind    = KIND_CURVE;
				push_entry.operand = raw01;
			end
			default: begin
				push_entry.kind    = KIND_UNKNOWN;
				push_entry.operand = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pgnd_queue.sv =====
// Two-entry queue between the classifier and the value unit.
// Uses pgnd_pkg and the assertion macros header.
`default_nettype none

module pgnd_queue
	import pgnd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  pgnd_entry_t      push_entry,
	input  wire logic        pop,
	output logic             full,
	output logic             not_empty,
	output pgnd_entry_t      head
);

	`include "j1939_pgn_field_decoder_unit_macros.svh"

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	pgnd_entry_t     mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`PGND_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full || pop)
	`PGND_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, not_empty)
	`PGND_ASSERT_NEXT(a_count_track, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

`default_nettype wire

// ===== rtl/pgnd_back.sv =====
// Value unit: two-stage pipeline that scales the operand by kind and holds
// the result for the output channel. Uses pgnd_pkg, pgnd_out_if, macros.
`default_nettype none

module pgnd_back
	import pgnd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  pgnd_entry_t      q_head,
	output logic             pop,
	pgnd_out_if.source       out_ch
);

	`include "j1939_pgn_field_decoder_unit_macros.svh"

	logic               valid_s1;
	pgnd_entry_t        ent_s1;
	logic [32:0]        prod_s1;
	logic               valid_s2;
	logic [15:0]        pgn_s2;
	kind_t              kind_s2;
	logic signed [16:0] value_s2;

	logic               adv_s1;
	logic               load_s1;
	logic [14:0]        pct100;
	logic [15:0]        mul_a;
	logic [16:0]        mul_b;
	logic [6:0]         q1000;
	logic [11:0]        speed;
	logic [16:0]        value_nx;

	// Handshake through the two stages
	assign adv_s1  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign load_s1 = !valid_s1 || adv_s1;
	assign pop     = q_valid && load_s1;

	// Stage 1 operands: one shared constant multiplier
	assign pct100 = {1'b0, q_head.operand[7:0], 6'b0} + {2'b0, q_head.operand[7:0], 5'b0}
		+ {5'b0, q_head.operand[7:0], 2'b0};
	always_comb begin
		case (q_head.kind)
			KIND_SPEED: begin
				mul_a = q_head.operand;
				mul_b = RECIP_1000;
			end
			default: begin
				mul_a = {1'b0, pct100};
				mul_b = RECIP_255;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1  <= q_head;
			prod_s1 <= 33'(mul_a) * 33'(mul_b);
		end
	end

	// Stage 2: final scaling per kind
	assign q1000 = prod_s1[SHIFT_1000 +: 7];
	assign speed = {q1000, 5'b0} + {3'b0, q1000, 2'b0};

	always_comb begin
		case (ent_s1.kind)
			KIND_ENGINE, KIND_REAR_PTO, KIND_FRNT_PTO:
				value_nx = {4'b0, ent_s1.operand[15:3]};
			KIND_SPEED:
				value_nx = {5'b0, speed};
			KIND_REAR_HTCH, KIND_FRNT_HTCH:
				value_nx = {10'b0, prod_s1[SHIFT_255 +: 7]};
			KIND_CURVE:
				value_nx = {1'b0, ent_s1.operand} - CURVE_OFFSET_Q;
			default:
				value_nx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pgn_s2   <= ent_s1.pgn;
			kind_s2  <= ent_s1.kind;
			value_s2 <= signed'(value_nx);
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.pgn   = pgn_s2;
	assign out_ch.kind  = kind_s2;
	assign out_ch.value = value_s2;

	`PGND_ASSERT_NOW(a_unknown_zero, clk, arst_n, valid_s2 && kind_s2 == KIND_UNKNOWN,
		value_s2 == '0)
	`PGND_ASSERT_NOW(a_speed_range, clk, arst_n, valid_s2 && kind_s2 == KIND_SPEED,
		value_s2 <= 17'sd2340)
	`PGND_ASSERT_NOW(a_hitch_range, clk, arst_n,
		valid_s2 && (kind_s2 == KIND_REAR_HTCH || kind_s2 == KIND_FRNT_HTCH),
		value_s2 <= 17'sd100)

endmodule

`default_nettype wire

// ===== rtl/j1939_pgn_field_decoder_unit.sv =====
// Top level of the J1939 PGN decoder: classifier, queue and value unit.
// Uses pgnd_pkg, pgnd_if, pgnd_front, pgnd_queue, pgnd_back.
//
// One received frame (29-bit extended identifier plus payload bytes 0..4)
// is taken per beat and yields exactly one result: the derived PGN, a kind
// code (0 when the group is not known) and the scaled value. A frame may be
// offered every cycle and one result leaves every cycle while the sink keeps
// ready high. On its way to the output, each classified beat is registered
// in the two-entry queue, then in the stage with the shared constant
// multiplier that handles the /1000 and /255 scalings, after which the
// output register presents the result. There is no configuration and no
// state beyond the pipeline; reset only empties the queue and the stages.
`default_nettype none

module j1939_pgn_field_decoder_unit
	import pgnd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pgnd_in_if.sink    in_ch,
	pgnd_out_if.source out_ch
);

	pgnd_entry_t push_entry;
	pgnd_entry_t head;
	logic        push;
	logic        pop;
	logic        full;
	logic        not_empty;

	// Classify incoming frames
	pgnd_front u_front (
		.in_ch      (in_ch),
		.q_full     (full),
		.push_entry (push_entry),
		.push       (push)
	);

	// Decouple classifier from value unit
	pgnd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Scale and deliver
	pgnd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_head  (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire
